FILE: design/chd_pkg.sv
// Shared types and constants for the canonical Huffman decoder.
// Depends on nothing; every other design file except chd_ram imports it.
package chd_pkg;

  localparam int MAX_LEN_DEF     = 32;
  localparam int NUM_SYMBOLS_DEF = 256;

  localparam int REQ_W   = 2;
  localparam int SYM_W   = 8;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int BCNT_W  = 4;
  localparam int CNT_W   = 9;
  localparam int CODE_W  = 33;
  localparam int FIRST_W = 34;

  localparam int TAB_DEPTH = 256;
  localparam int TAB_AW    = 8;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 8;

  localparam logic [BCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_STREAM = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_OLD,
    ST_LD_DEC,
    ST_LD_RDNEW,
    ST_LD_INC,
    ST_BD_CNT,
    ST_BD_CHK,
    ST_BD_SWEEP,
    ST_BD_DRAIN,
    ST_DC_BIT,
    ST_DC_EMIT,
    ST_DC_END
  } ctrl_state_t;

  typedef struct packed {
    logic restart;
    logic load;
    logic step;
  } dec_cmd_t;

  typedef struct packed {
    logic              match;
    logic              error;
    logic              last_bit;
    logic [TAB_AW-1:0] idx;
  } dec_stat_t;

  typedef struct packed {
    logic             push;
    logic             flush;
    logic [SYM_W-1:0] sym;
    logic             err;
  } out_cmd_t;

endpackage

FILE: design/canonical_huffman_decoder_top.sv
// Canonical Huffman decoder, top level: stream ports, memories and the three working parts.
// Depends on chd_pkg, chd_ram, chd_ctrl, chd_bitdec and chd_outq.
//
// One item is taken at a time. A load item reads the old length and its count, decrements
// that count, reads the new length's count, then increments it and writes the new length. A build
// item checks each code length from 1 to MAX_LEN, sweeping the symbol-length memory once per used length.
// A stream item resolves one bit per cycle, paced by the registered read of the per-length count
// for the next bit, except while a result is read from the sorted table and pushed or the run's
// last result is marked; output back-pressure can hold it there.
module canonical_huffman_decoder_top import chd_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // symbol[7:0], code_length[13:8], stream_byte[21:14], bit_count[25:22], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [REQ_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // decoded_symbol[7:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // code_error[0]
  output logic [0:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int CA_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_AW = $clog2(NUM_SYMBOLS);

  localparam int SYM_LO  = 0;
  localparam int LEN_LO  = SYM_LO + SYM_W;
  localparam int BYTE_LO = LEN_LO + LEN_W;
  localparam int BCNT_LO = BYTE_LO + BYTE_W;

  logic [SYM_W-1:0]  symbol;
  logic [LEN_W-1:0]  code_length;
  logic [BYTE_W-1:0] stream_byte;
  logic [BCNT_W-1:0] bit_count;

  assign symbol      = s_axis_tdata[SYM_LO +: SYM_W];
  assign code_length = s_axis_tdata[LEN_LO +: LEN_W];
  assign stream_byte = s_axis_tdata[BYTE_LO +: BYTE_W];
  assign bit_count   = s_axis_tdata[BCNT_LO +: BCNT_W];

  logic              cnt_we, cnt_re;
  logic [CA_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              len_we, len_re;
  logic [SYM_AW-1:0] len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata, len_rdata;
  logic              tab_we, tab_re;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  logic [SYM_W-1:0]  tab_wdata, tab_rdata;

  dec_cmd_t          dcmd;
  dec_stat_t         dstat;
  logic [CA_W-1:0]   len_now, len_next;
  logic [CNT_W-1:0]  count_val;
  out_cmd_t          ocmd;
  logic              out_ok;
  logic [SYM_W-1:0]  m_sym;
  logic              m_err;

  chd_ram #(.W(CNT_W), .DEPTH(MAX_LEN + 1)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  chd_ram #(.W(LEN_W), .DEPTH(NUM_SYMBOLS)) u_length_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  chd_ram #(.W(SYM_W), .DEPTH(TAB_DEPTH)) u_table_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  chd_ctrl #(.MAX_LEN(MAX_LEN), .NUM_SYMBOLS(NUM_SYMBOLS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .req         (s_axis_tuser),
    .symbol      (symbol),
    .code_length (code_length),
    .bit_count   (bit_count),
    .cnt_we      (cnt_we),
    .cnt_waddr   (cnt_waddr),
    .cnt_wdata   (cnt_wdata),
    .cnt_re      (cnt_re),
    .cnt_raddr   (cnt_raddr),
    .cnt_rdata   (cnt_rdata),
    .len_we      (len_we),
    .len_waddr   (len_waddr),
    .len_wdata   (len_wdata),
    .len_re      (len_re),
    .len_raddr   (len_raddr),
    .len_rdata   (len_rdata),
    .tab_we      (tab_we),
    .tab_waddr   (tab_waddr),
    .tab_wdata   (tab_wdata),
    .tab_re      (tab_re),
    .tab_raddr   (tab_raddr),
    .tab_rdata   (tab_rdata),
    .dcmd        (dcmd),
    .dstat       (dstat),
    .len_now     (len_now),
    .len_next    (len_next),
    .count_val   (count_val),
    .ocmd        (ocmd),
    .out_ok      (out_ok)
  );

  chd_bitdec #(.MAX_LEN(MAX_LEN)) u_bitdec (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dcmd),
    .stream_byte (stream_byte),
    .bit_count   (bit_count),
    .count       (count_val),
    .stat        (dstat),
    .len_now     (len_now),
    .len_next    (len_next)
  );

  chd_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ocmd),
    .ok      (out_ok),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_sym   (m_sym),
    .m_err   (m_err),
    .m_last  (m_axis_tlast)
  );

  assign m_axis_tdata = M_TDATA_W'(m_sym);
  assign m_axis_tuser = m_err;

endmodule

FILE: design/chd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module chd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/chd_bitdec.sv
// Bit-serial code resolver: byte shift register and the running canonical code state.
// Depends on chd_pkg.
module chd_bitdec import chd_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF,
  localparam int CA_W   = $clog2(MAX_LEN + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  dec_cmd_t          cmd,
  input  logic [BYTE_W-1:0] stream_byte,
  input  logic [BCNT_W-1:0] bit_count,
  input  logic [CNT_W-1:0]  count,
  output dec_stat_t         stat,
  output logic [CA_W-1:0]   len_now,
  output logic [CA_W-1:0]   len_next
);

  logic [CODE_W-1:0]  partial_code;
  logic [FIRST_W-1:0] first_code;
  logic [CNT_W-1:0]   rank_base;
  logic [CA_W-1:0]    bits_taken;
  logic [BYTE_W-1:0]  byte_sr;
  logic [BCNT_W-1:0]  rem;

  logic [CODE_W-1:0]  code;
  logic [FIRST_W-1:0] code_ext;
  logic [FIRST_W-1:0] diff;
  logic [FIRST_W-1:0] first_add;
  logic               in_range;
  logic               at_max;

  assign code      = partial_code | CODE_W'(byte_sr[BYTE_W-1]);
  assign code_ext  = FIRST_W'(code);
  assign diff      = code_ext - first_code;
  assign in_range  = (code_ext >= first_code) && (diff < FIRST_W'(count));
  assign first_add = first_code + FIRST_W'(count);
  assign len_now   = bits_taken + CA_W'(1);
  assign len_next  = len_now + CA_W'(1);
  assign at_max    = (len_now == CA_W'(MAX_LEN));

  assign stat.match    = in_range;
  assign stat.error    = !in_range && at_max;
  assign stat.last_bit = (rem == BCNT_W'(1));
  assign stat.idx      = rank_base[TAB_AW-1:0] + diff[TAB_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code <= '0;
      first_code   <= '0;
      rank_base    <= '0;
      bits_taken   <= '0;
      rem          <= '0;
    end else begin
      if (cmd.restart) begin
        partial_code <= '0;
        first_code   <= '0;
        rank_base    <= '0;
        bits_taken   <= '0;
      end
      if (cmd.load) begin
        rem <= (bit_count > BITS_PER_BYTE) ? BITS_PER_BYTE : bit_count;
      end
      if (cmd.step) begin
        rem <= rem - BCNT_W'(1);
        if (in_range || at_max) begin
          partial_code <= '0;
          first_code   <= '0;
          rank_base    <= '0;
          bits_taken   <= '0;
        end else begin
          partial_code <= {code[CODE_W-2:0], 1'b0};
          first_code   <= {first_add[FIRST_W-2:0], 1'b0};
          rank_base    <= rank_base + count;
          bits_taken   <= len_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_sr <= stream_byte;
    end else if (cmd.step) begin
      byte_sr <= {byte_sr[BYTE_W-2:0], 1'b0};
    end
  end

  a_step_has_bits: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> rem != '0)
    else $error("bit step with no bits left in the byte");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> 32'(bits_taken) < MAX_LEN)
    else $error("code grew past the maximum length");

endmodule

FILE: design/chd_outq.sv
// Result staging: a hold register that waits to learn whether its item ends the run,
// then the output register. Depends on chd_pkg.
module chd_outq import chd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  out_cmd_t         cmd,
  output logic             ok,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [SYM_W-1:0] m_sym,
  output logic             m_err,
  output logic             m_last
);

  logic             hold_vld;
  logic [SYM_W-1:0] hold_sym;
  logic             hold_err;
  logic             out_free;
  logic             move;

  assign out_free = !m_valid || m_ready;
  assign ok       = !hold_vld || out_free;
  assign move     = hold_vld && out_free && (cmd.push || cmd.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      if (out_free) begin
        m_valid <= move;
      end
      if (cmd.push && ok) begin
        hold_vld <= 1'b1;
      end else if (cmd.flush && move) begin
        hold_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_sym  <= hold_sym;
      m_err  <= hold_err;
      m_last <= cmd.flush;
    end
    if (cmd.push && ok) begin
      hold_sym <= cmd.sym;
      hold_err <= cmd.err;
    end
  end

  a_push_flush_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.flush))
    else $error("push and flush together");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush && ok) |=> !hold_vld)
    else $error("held item survived a flush");

endmodule

FILE: design/chd_ctrl.sv
// Sequencer for loads, table builds and stream decoding; owns the valid bits of
// the count and length memories. Depends on chd_pkg.
module chd_ctrl import chd_pkg::*; #(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
  localparam int CA_W       = $clog2(MAX_LEN + 1),
  localparam int SYM_AW     = $clog2(NUM_SYMBOLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [REQ_W-1:0]  req,
  input  logic [SYM_W-1:0]  symbol,
  input  logic [LEN_W-1:0]  code_length,
  input  logic [BCNT_W-1:0] bit_count,
  output logic              cnt_we,
  output logic [CA_W-1:0]   cnt_waddr,
  output logic [CNT_W-1:0]  cnt_wdata,
  output logic              cnt_re,
  output logic [CA_W-1:0]   cnt_raddr,
  input  logic [CNT_W-1:0]  cnt_rdata,
  output logic              len_we,
  output logic [SYM_AW-1:0] len_waddr,
  output logic [LEN_W-1:0]  len_wdata,
  output logic              len_re,
  output logic [SYM_AW-1:0] len_raddr,
  input  logic [LEN_W-1:0]  len_rdata,
  output logic              tab_we,
  output logic [TAB_AW-1:0] tab_waddr,
  output logic [SYM_W-1:0]  tab_wdata,
  output logic              tab_re,
  output logic [TAB_AW-1:0] tab_raddr,
  input  logic [SYM_W-1:0]  tab_rdata,
  output dec_cmd_t          dcmd,
  input  dec_stat_t         dstat,
  input  logic [CA_W-1:0]   len_now,
  input  logic [CA_W-1:0]   len_next,
  output logic [CNT_W-1:0]  count_val,
  output out_cmd_t          ocmd,
  input  logic              out_ok
);

  ctrl_state_t state, state_next;

  logic [SYM_AW-1:0] ld_sym;
  logic [LEN_W-1:0]  ld_len;
  logic [LEN_W-1:0]  ld_old;
  logic [CA_W-1:0]   blen;
  logic [SYM_AW-1:0] bsym;
  logic [SYM_AW-1:0] psym;
  logic              sweep_pend;
  logic [TAB_AW-1:0] pos;
  logic              emit_err;
  logic              emit_last;
  logic              cnt_vld [MAX_LEN + 1];
  logic              len_vld [NUM_SYMBOLS];
  logic              cnt_rvld;
  logic              len_rvld;

  logic              accept;
  req_t              rq;
  logic              sym_ok;
  logic [LEN_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  len_stored;
  logic              blen_last;

  assign s_ready    = (state == ST_IDLE);
  assign accept     = s_valid && s_ready;
  assign rq         = req_t'(req);
  assign sym_ok     = 32'(symbol) < NUM_SYMBOLS;
  assign len_clamp  = (32'(code_length) > MAX_LEN) ? '0 : code_length;
  assign len_stored = len_rvld ? len_rdata : '0;
  assign count_val  = cnt_rvld ? cnt_rdata : '0;
  assign blen_last  = (blen == CA_W'(MAX_LEN));

  assign len_waddr = ld_sym;
  assign len_wdata = ld_len;
  assign tab_we    = sweep_pend && (CA_W'(len_stored) == blen);
  assign tab_waddr = pos;
  assign tab_wdata = SYM_W'(psym);
  assign tab_raddr = dstat.idx;

  always_comb begin
    state_next = state;
    cnt_re     = 1'b0;
    cnt_raddr  = len_now;
    cnt_we     = 1'b0;
    cnt_waddr  = CA_W'(ld_len);
    cnt_wdata  = count_val + CNT_W'(1);
    len_re     = 1'b0;
    len_raddr  = bsym;
    len_we     = 1'b0;
    tab_re     = 1'b0;
    dcmd       = '0;
    ocmd.push  = 1'b0;
    ocmd.flush = 1'b0;
    ocmd.sym   = emit_err ? '0 : tab_rdata;
    ocmd.err   = emit_err;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (rq)
            REQ_LOAD: begin
              if (sym_ok) begin
                len_re     = 1'b1;
                len_raddr  = SYM_AW'(symbol);
                state_next = ST_LD_OLD;
              end
            end
            REQ_BUILD: begin
              dcmd.restart = 1'b1;
              state_next   = ST_BD_CNT;
            end
            REQ_STREAM: begin
              if (bit_count != '0) begin
                dcmd.load  = 1'b1;
                cnt_re     = 1'b1;
                state_next = ST_DC_BIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LD_OLD: begin
        cnt_re     = 1'b1;
        cnt_raddr  = CA_W'(len_stored);
        state_next = ST_LD_DEC;
      end
      ST_LD_DEC: begin
        if (ld_old != '0 && count_val != '0) begin
          cnt_we    = 1'b1;
          cnt_waddr = CA_W'(ld_old);
          cnt_wdata = count_val - CNT_W'(1);
        end
        state_next = ST_LD_RDNEW;
      end
      ST_LD_RDNEW: begin
        cnt_re     = 1'b1;
        cnt_raddr  = CA_W'(ld_len);
        state_next = ST_LD_INC;
      end
      ST_LD_INC: begin
        cnt_we     = (ld_len != '0);
        len_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_BD_CNT: begin
        cnt_re     = 1'b1;
        cnt_raddr  = blen;
        state_next = ST_BD_CHK;
      end
      ST_BD_CHK: begin
        if (count_val != '0) begin
          state_next = ST_BD_SWEEP;
        end else if (blen_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_BD_CNT;
        end
      end
      ST_BD_SWEEP: begin
        len_re = 1'b1;
        if (bsym == SYM_AW'(NUM_SYMBOLS - 1)) begin
          state_next = ST_BD_DRAIN;
        end
      end
      ST_BD_DRAIN: begin
        state_next = blen_last ? ST_IDLE : ST_BD_CNT;
      end
      ST_DC_BIT: begin
        dcmd.step = 1'b1;
        if (dstat.match) begin
          tab_re     = 1'b1;
          state_next = ST_DC_EMIT;
        end else if (dstat.error) begin
          state_next = ST_DC_EMIT;
        end else if (dstat.last_bit) begin
          state_next = ST_DC_END;
        end else begin
          cnt_re    = 1'b1;
          cnt_raddr = len_next;
        end
      end
      ST_DC_EMIT: begin
        if (out_ok) begin
          ocmd.push = 1'b1;
          if (emit_last) begin
            state_next = ST_DC_END;
          end else begin
            cnt_re     = 1'b1;
            state_next = ST_DC_BIT;
          end
        end
      end
      ST_DC_END: begin
        ocmd.flush = 1'b1;
        if (out_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sweep_pend <= 1'b0;
      cnt_rvld   <= 1'b0;
      len_rvld   <= 1'b0;
      for (int i = 0; i <= MAX_LEN; i++) begin
        cnt_vld[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        len_vld[i] <= 1'b0;
      end
    end else begin
      state      <= state_next;
      sweep_pend <= (state == ST_BD_SWEEP);
      if (cnt_re) begin
        cnt_rvld <= cnt_vld[cnt_raddr];
      end
      if (len_re) begin
        len_rvld <= len_vld[len_raddr];
      end
      if (cnt_we) begin
        cnt_vld[cnt_waddr] <= 1'b1;
      end
      if (len_we) begin
        len_vld[len_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_sym <= SYM_AW'(symbol);
      ld_len <= len_clamp;
      blen   <= CA_W'(1);
      pos    <= '0;
    end
    if (state == ST_LD_OLD) begin
      ld_old <= len_stored;
    end
    if ((state == ST_BD_CHK && count_val == '0 && !blen_last) ||
        (state == ST_BD_DRAIN && !blen_last)) begin
      blen <= blen + CA_W'(1);
    end
    if (state == ST_BD_CHK) begin
      bsym <= '0;
    end else if (state == ST_BD_SWEEP) begin
      bsym <= bsym + SYM_AW'(1);
      psym <= bsym;
    end
    if (tab_we) begin
      pos <= pos + TAB_AW'(1);
    end
    if (state == ST_DC_BIT) begin
      emit_err  <= !dstat.match;
      emit_last <= dstat.last_bit;
    end
  end

  a_stream_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && rq == REQ_STREAM && bit_count != '0) |=> state == ST_DC_BIT)
    else $error("stream item did not start bit decoding");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (!cnt_re || cnt_waddr != cnt_raddr))
    else $error("count memory read and written at one address");

endmodule

FILE: bench/chd_decode_sb_pkg.sv
// Scoreboard for the canonical Huffman decoder bench: a bit-level decode model and result queue.
// Depends on chd_pkg for field widths, request codes and the code length limit.
package chd_decode_sb_pkg;
  import chd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
    logic             last;
  } decoded_t;

  class canon_decode_tracker;
    logic [CNT_W-1:0]   per_len_count [0:MAX_LEN_DEF];
    logic [LEN_W-1:0]   sym_len [0:TAB_DEPTH-1];
    logic [SYM_W-1:0]   canon_order [0:TAB_DEPTH-1];
    logic [CODE_W-1:0]  code_acc;
    logic [FIRST_W-1:0] len_first;
    logic [CNT_W-1:0]   len_rank;
    logic [LEN_W-1:0]   depth;
    decoded_t           awaited[$];
    int unsigned        mismatches;
    int unsigned        symbols_seen;
    int unsigned        errors_seen;
    int unsigned        tables_built;

    function new();
      foreach (per_len_count[i]) per_len_count[i] = '0;
      foreach (sym_len[i]) sym_len[i] = '0;
      foreach (canon_order[i]) canon_order[i] = '0;
      restart();
      mismatches   = 0;
      symbols_seen = 0;
      errors_seen  = 0;
      tables_built = 0;
    endfunction

    function void restart();
      code_acc  = '0;
      len_first = '0;
      len_rank  = '0;
      depth     = '0;
    endfunction

    function void accept_request(logic [REQ_W-1:0] req, logic [SYM_W-1:0] sym,
                                 logic [LEN_W-1:0] len, logic [BYTE_W-1:0] bits,
                                 logic [BCNT_W-1:0] cnt);
      logic [LEN_W-1:0] new_len;
      logic [LEN_W-1:0] old_len;
      logic [63:0]      code_w;
      logic [63:0]      first_w;
      logic [63:0]      span;
      logic [63:0]      idx_w;
      logic [63:0]      next_first;
      logic [63:0]      next_code;
      decoded_t         one;
      decoded_t         burst[$];
      int               pos;
      int               nbits;
      int               l;
      if (req == REQ_LOAD) begin
        new_len = (len > MAX_LEN_DEF) ? '0 : len;
        old_len = sym_len[sym];
        if (old_len != 0 && per_len_count[old_len] != 0)
          per_len_count[old_len] = per_len_count[old_len] - 1'b1;
        if (new_len != 0)
          per_len_count[new_len] = per_len_count[new_len] + 1'b1;
        sym_len[sym] = new_len;
      end else if (req == REQ_BUILD) begin
        pos = 0;
        for (int ln = 1; ln <= MAX_LEN_DEF; ln++) begin
          for (int s = 0; s < NUM_SYMBOLS_DEF; s++) begin
            if (sym_len[s] == ln) begin
              canon_order[pos % TAB_DEPTH] = SYM_W'(s);
              pos++;
            end
          end
        end
        restart();
        tables_built++;
      end else if (req == REQ_STREAM) begin
        nbits = (cnt > BITS_PER_BYTE) ? 8 : int'(cnt);
        for (int i = 0; i < nbits; i++) begin
          l       = int'(depth) + 1;
          span    = (l <= MAX_LEN_DEF) ? 64'(per_len_count[l]) : 64'd0;
          code_w  = 64'(code_acc) | 64'(bits[7-i]);
          first_w = 64'(len_first);
          if (code_w >= first_w && code_w - first_w < span) begin
            idx_w    = 64'(len_rank) + (code_w - first_w);
            one.sym  = canon_order[idx_w[TAB_AW-1:0]];
            one.err  = 1'b0;
            one.last = 1'b0;
            burst    = {burst, one};
            restart();
          end else begin
            next_first = (first_w + span) << 1;
            next_code  = code_w << 1;
            len_rank   = len_rank + span[CNT_W-1:0];
            len_first  = next_first[FIRST_W-1:0];
            code_acc   = next_code[CODE_W-1:0];
            depth      = LEN_W'(l);
            if (l >= MAX_LEN_DEF) begin
              one.sym  = '0;
              one.err  = 1'b1;
              one.last = 1'b0;
              burst    = {burst, one};
              restart();
            end
          end
        end
        if (burst.size() > 0) begin
          one = burst[burst.size()-1];
          one.last = 1'b1;
          burst[burst.size()-1] = one;
        end
        awaited = {awaited, burst};
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 200) $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_symbol(logic [SYM_W-1:0] sym, logic err, logic last);
      decoded_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("item sym=%0h err=%0b last=%0b with none due", sym, err, last));
      end else begin
        want = awaited.pop_front();
        if (sym !== want.sym)
          report_mismatch($sformatf("decoded_symbol %0h, want %0h", sym, want.sym));
        if (err !== want.err)
          report_mismatch($sformatf("code_error %0b, want %0b", err, want.err));
        if (last !== want.last)
          report_mismatch($sformatf("tlast %0b, want %0b", last, want.last));
        if (want.err) errors_seen++;
        else symbols_seen++;
      end
    endtask
  endclass

endpackage

FILE: bench/canonical_huffman_decoder_top_test.sv
// Bench top for canonical_huffman_decoder_top: directed and random code tables and bit streams.
// Depends on chd_pkg, chd_decode_sb_pkg and the decoder RTL.
module canonical_huffman_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;
  import chd_decode_sb_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 500;
  localparam int QUIET_FROM  = 420;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [REQ_W-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  canon_decode_tracker tracker;
  logic [SYM_W-1:0]    live_syms[$];
  int                  useful_items;
  int                  all_items;
  int                  cycles;
  int                  stall_left;
  bit                  idle_on;

  canonical_huffman_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_symbol(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_request(input int req, input int sym, input int len, input int bits,
                              input int cnt);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req[REQ_W-1:0];
    s_axis_tdata  <= {6'b0, cnt[BCNT_W-1:0], bits[BYTE_W-1:0], len[LEN_W-1:0], sym[SYM_W-1:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.accept_request(req[REQ_W-1:0], sym[SYM_W-1:0], len[LEN_W-1:0], bits[BYTE_W-1:0],
                           cnt[BCNT_W-1:0]);
    all_items++;
    if (req == REQ_LOAD || req == REQ_BUILD || (req == REQ_STREAM && cnt[BCNT_W-1:0] != 0))
      useful_items++;
    if (useful_items >= QUIET_FROM) idle_on = 1'b0;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic push_byte(input int bits, input int cnt);
    push_request(REQ_STREAM, $urandom_range(0, 255), $urandom_range(0, 63), bits, cnt);
  endtask

  // shape 0: complete prefix code, 1: complete chain (deep codes), 2: arbitrary lengths
  task automatic run_code_phase(input int shape, input int nsym);
    int               leaf_depth[$];
    bit               taken[TAB_DEPTH];
    logic [SYM_W-1:0] chosen[$];
    int               pick;
    int               s;
    int               r;
    int               cnt;
    int               bits;
    int               nstream;
    if ($urandom_range(0, 4) != 0) begin
      foreach (live_syms[k])
        push_request(REQ_LOAD, live_syms[k],
                     ($urandom_range(0, 2) == 0) ? $urandom_range(33, 63) : 0, 0, 0);
      live_syms.delete();
    end
    if (shape == 2) begin
      for (int k = 0; k < nsym; k++)
        leaf_depth = {leaf_depth, int'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 6)
                                       : $urandom_range(1, MAX_LEN_DEF))};
    end else begin
      leaf_depth = {leaf_depth, int'(0)};
      for (int k = 1; k < nsym; k++) begin
        pick = 0;
        if (shape == 1) begin
          foreach (leaf_depth[j]) if (leaf_depth[j] > leaf_depth[pick]) pick = j;
        end else begin
          pick = $urandom_range(0, leaf_depth.size() - 1);
          if (leaf_depth[pick] >= 12)
            foreach (leaf_depth[j]) if (leaf_depth[j] < leaf_depth[pick]) pick = j;
        end
        leaf_depth[pick] = leaf_depth[pick] + 1;
        leaf_depth = {leaf_depth, leaf_depth[pick]};
      end
    end
    foreach (taken[k]) taken[k] = 1'b0;
    for (int k = 0; k < nsym; k++) begin
      do s = $urandom_range(0, 255); while (taken[s]);
      taken[s] = 1'b1;
      chosen = {chosen, SYM_W'(s)};
    end
    foreach (chosen[k]) begin
      if ($urandom_range(0, 5) == 0)
        push_request(REQ_LOAD, chosen[k], $urandom_range(1, MAX_LEN_DEF), 0, 0);
      push_request(REQ_LOAD, chosen[k], leaf_depth[k], 0, 0);
      live_syms = {live_syms, chosen[k]};
    end
    push_request(REQ_BUILD, 0, 0, 0, 0);
    if ($urandom_range(0, 2) == 0) wait_for_results();
    nstream = $urandom_range(10, 30);
    for (int k = 0; k < nstream; k++) begin
      r = $urandom_range(0, 39);
      if (r == 0) begin
        push_request(REQ_SPARE, $urandom_range(0, 255), $urandom_range(0, 63), 0, 8);
      end else if (r == 1) begin
        push_request(REQ_BUILD, 0, 0, 0, 0);
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) cnt = 0;
        else if (r == 1) cnt = $urandom_range(9, 15);
        else if (r < 5) cnt = $urandom_range(1, 7);
        else cnt = 8;
        r = $urandom_range(0, 9);
        if (r < 2) bits = 8'hFF;
        else if (r == 2) bits = 8'h00;
        else bits = $urandom_range(0, 255);
        push_byte(bits, cnt);
      end
    end
  endtask

  initial begin
    int shape;
    tracker = new();
    useful_items  = 0;
    all_items     = 0;
    idle_on       = 1'b1;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_LOAD;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty code set: 32 bits then an error, including a byte with an oversized count
    push_request(REQ_BUILD, 0, 0, 0, 0);
    push_byte(8'hFF, 8);
    push_byte(8'hFF, 8);
    push_byte(8'h00, 15);
    push_byte(8'h3C, 8);
    push_byte(8'h5A, 0);
    // lengths 1, 2, 3 and 32; one overlong length, two reloads
    push_request(REQ_LOAD, 255, 1, 0, 0);
    push_request(REQ_LOAD, 0, 2, 0, 0);
    push_request(REQ_LOAD, 100, 3, 0, 0);
    push_request(REQ_LOAD, 7, 63, 0, 0);
    push_request(REQ_LOAD, 7, 5, 0, 0);
    push_request(REQ_LOAD, 7, MAX_LEN_DEF, 0, 0);
    push_request(REQ_BUILD, 0, 0, 0, 0);
    push_byte(8'hE0, 8);
    push_byte(8'h00, 8);
    push_byte(8'h00, 8);
    push_byte(8'h00, 8);
    push_byte(8'hFF, 8);
    push_byte(8'hFF, 8);
    push_byte(8'hFF, 8);
    push_byte(8'hFF, 8);
    push_request(REQ_SPARE, 255, 63, 255, 15);
    push_byte(8'h4B, 7);
    wait_for_results();
    live_syms = '{8'd255, 8'd0, 8'd100, 8'd7};

    run_code_phase(1, MAX_LEN_DEF + 1);
    while (useful_items < ITEM_TARGET) begin
      shape = $urandom_range(0, 3);
      if (shape == 3) shape = 0;
      run_code_phase(shape, (shape == 1) ? $urandom_range(2, 12) : $urandom_range(2, 16));
    end

    s_axis_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items (%0d doing work) across %0d table builds in %0d cycles",
             all_items, useful_items, tracker.tables_built, cycles);
    $display("Checked %0d decoded symbols and %0d overlong-code errors, %0d mismatches",
             tracker.symbols_seen, tracker.errors_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
